@@ rtl/core/tcw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg: shared definitions for the text console character writer
// Field widths, geometry, reset values, command and control character codes.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // Field widths of the transaction payloads
    localparam int POS_W  = 11;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int CELL_W = 16;

    // Default screen geometry
    localparam int COLUMNS_DEF  = 80;
    localparam int ROWS_DEF     = 25;
    localparam int TAB_STOP_DEF = 4;

    // Reset values
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;
    localparam logic [CELL_W-1:0] CELL_RESET = 16'h0F20;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_NULL    = 8'h00;

    // Command codes
    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Control character codes
    localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
    localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;

endpackage

@@ rtl/core/tcw_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/text_console_char_writer_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_char_writer_unit: text-mode console engine
// Keeps a COLUMNS x ROWS screen of attribute/character cells and a cursor.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one command per
//   transaction: put a byte (i_cmd = 0) or read a cell (i_cmd = 1).
//   Output channel (o_out_valid / i_out_ready) returns one result per
//   command: cursor, line start and the cell read (0 for a put).
//   i_cfg_we / i_cfg_wdata set the attribute byte used for new cells.
//   One command is in work at a time. NUL or an out-of-range read goes
//   straight to the finish state; a printable byte or backspace passes the
//   scroll check, and an in-range read the capture of the cell read. Tab,
//   newline or carriage return pass a divide step, in which a reciprocal
//   multiply finds the quotient of the cursor, then the apply step and the
//   scroll check. o_in_ready rises in the same cycle the result is loaded.
//   A scroll moves each cell below the top row one row up through the one
//   RAM port pair, then blanks the bottom row.
//   After reset a clearing pass writes every cell, and o_in_ready stays low
//   during it.
//   A stalled receiver holds the result register; the next command is
//   accepted meanwhile and its result waits until the register frees.
// ----------------------------------------------------------------------------
module text_console_char_writer_unit #(
    parameter int COLUMNS  = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS     = tcw_pkg::ROWS_DEF,
    parameter int TAB_STOP = tcw_pkg::TAB_STOP_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [tcw_pkg::ATTR_W-1:0]  i_cfg_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_cmd,
    input  logic [tcw_pkg::CHAR_W-1:0]  i_char_code,
    input  logic [tcw_pkg::POS_W-1:0]   i_cell_index,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [tcw_pkg::POS_W-1:0]   o_cursor_pos,
    output logic [tcw_pkg::POS_W-1:0]   o_line_start,
    output logic [tcw_pkg::CELL_W-1:0]  o_cell_value
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int DMAX       = (COLUMNS > TAB_STOP) ? COLUMNS : TAB_STOP;
    localparam int AW         = $clog2(CELL_COUNT);
    localparam int CW         = $clog2(CELL_COUNT + DMAX);
    localparam int RW         = CW + 2;
    localparam int PW         = CW + RW;
    localparam int TAB_SH     = CW + $clog2(TAB_STOP);
    localparam int COL_SH     = CW + $clog2(COLUMNS);
    localparam int TAB_RECIP  = ((1 << TAB_SH) + TAB_STOP - 1) / TAB_STOP;
    localparam int COL_RECIP  = ((1 << COL_SH) + COLUMNS - 1) / COLUMNS;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD_DATA,
        S_DIV,
        S_APPLY,
        S_CHECK,
        S_SC_RD,
        S_SC_WR,
        S_SC_FILL,
        S_FINISH
    } t_state;

    t_state                       r_state, n_state;
    logic [AW-1:0]                r_scan, n_scan;
    logic [CW-1:0]                r_cursor, n_cursor;
    logic [CW-1:0]                r_line, n_line;
    logic [tcw_pkg::ATTR_W-1:0]   r_attr, n_attr;
    logic [tcw_pkg::CHAR_W-1:0]   r_char, n_char;
    logic [tcw_pkg::CELL_W-1:0]   r_value, n_value;
    logic [CW-1:0]                r_quo, n_quo;
    logic                         r_out_valid, n_out_valid;
    logic [tcw_pkg::POS_W-1:0]    r_out_cursor, n_out_cursor;
    logic [tcw_pkg::POS_W-1:0]    r_out_line, n_out_line;
    logic [tcw_pkg::CELL_W-1:0]   r_out_value, n_out_value;

    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [tcw_pkg::CELL_W-1:0]   ram_wdata;
    logic [AW-1:0]                ram_raddr;
    logic [tcw_pkg::CELL_W-1:0]   ram_rdata;

    logic                         w_accept;
    logic [RW-1:0]                w_recip;
    logic [PW-1:0]                w_product;
    logic [CW-1:0]                w_quo;
    logic [CW-1:0]                w_row_start;
    logic [CW-1:0]                w_tab_base;
    logic [CW-1:0]                w_bs_cursor;

    tcw_ram #(
        .WIDTH (tcw_pkg::CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_ready   = (r_state == S_IDLE);
    assign w_accept     = i_in_valid && o_in_ready;
    assign o_out_valid  = r_out_valid;
    assign o_cursor_pos = r_out_cursor;
    assign o_line_start = r_out_line;
    assign o_cell_value = r_out_value;

    // Shared multiplier: quotient of the cursor by the tab stop or the row width
    assign w_recip     = (r_char == tcw_pkg::CH_TAB) ? RW'(TAB_RECIP) : RW'(COL_RECIP);
    assign w_product   = PW'(r_cursor) * PW'(w_recip);
    assign w_quo       = (r_char == tcw_pkg::CH_TAB) ? CW'(w_product >> TAB_SH)
                                                     : CW'(w_product >> COL_SH);
    assign w_row_start = r_quo * CW'(COLUMNS);
    assign w_tab_base  = r_quo * CW'(TAB_STOP);
    assign w_bs_cursor = (r_line < r_cursor) ? (r_cursor - CW'(1)) : r_cursor;

    // Sequencer next-state logic
    always_comb begin
        n_state      = r_state;
        n_scan       = r_scan;
        n_cursor     = r_cursor;
        n_line       = r_line;
        n_attr       = i_cfg_we ? i_cfg_wdata : r_attr;
        n_char       = r_char;
        n_value      = r_value;
        n_quo        = r_quo;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_cursor = r_out_cursor;
        n_out_line   = r_out_line;
        n_out_value  = r_out_value;
        ram_we       = 1'b0;
        ram_waddr    = r_scan;
        ram_wdata    = tcw_pkg::CELL_RESET;
        ram_raddr    = r_scan;

        case (r_state)
            // Write the reset cell into every entry
            S_CLEAR: begin
                ram_we = 1'b1;
                if (r_scan == AW'(CELL_COUNT - 1)) begin
                    n_scan  = '0;
                    n_state = S_IDLE;
                end else begin
                    n_scan = r_scan + AW'(1);
                end
            end

            // Take a transaction and start its work
            S_IDLE: begin
                ram_raddr = AW'(i_cell_index);
                if (w_accept) begin
                    n_char  = i_char_code;
                    n_value = '0;
                    if (i_cmd == tcw_pkg::CMD_READ) begin
                        if (32'(i_cell_index) < CELL_COUNT) begin
                            n_state = S_RD_DATA;
                        end else begin
                            n_state = S_FINISH;
                        end
                    end else begin
                        case (i_char_code)
                            tcw_pkg::CH_NUL: begin
                                n_state = S_FINISH;
                            end
                            tcw_pkg::CH_TAB, tcw_pkg::CH_LF, tcw_pkg::CH_CR: begin
                                n_state = S_DIV;
                            end
                            tcw_pkg::CH_BS: begin
                                ram_we    = 1'b1;
                                ram_waddr = AW'(w_bs_cursor);
                                ram_wdata = {r_attr, tcw_pkg::CH_NULL};
                                n_cursor  = w_bs_cursor;
                                n_state   = S_CHECK;
                            end
                            default: begin
                                ram_we    = 1'b1;
                                ram_waddr = AW'(r_cursor);
                                ram_wdata = {r_attr, i_char_code};
                                n_cursor  = r_cursor + CW'(1);
                                n_state   = S_CHECK;
                            end
                        endcase
                    end
                end
            end

            // Capture the cell read
            S_RD_DATA: begin
                n_value = ram_rdata;
                n_state = S_FINISH;
            end

            // Hold the quotient of the cursor
            S_DIV: begin
                n_quo   = w_quo;
                n_state = S_APPLY;
            end

            // Move the cursor to the next stop or row boundary
            S_APPLY: begin
                n_state = S_CHECK;
                case (r_char)
                    tcw_pkg::CH_TAB: begin
                        n_cursor = w_tab_base + CW'(TAB_STOP);
                    end
                    tcw_pkg::CH_LF: begin
                        ram_we    = 1'b1;
                        ram_waddr = AW'(r_cursor);
                        ram_wdata = '0;
                        n_cursor  = w_row_start + CW'(COLUMNS);
                        n_line    = w_row_start + CW'(COLUMNS);
                    end
                    default: begin
                        n_cursor = w_row_start;
                        n_line   = w_row_start;
                    end
                endcase
            end

            // Scroll while the cursor is past the last cell
            S_CHECK: begin
                if (r_cursor >= CW'(CELL_COUNT)) begin
                    n_scan  = AW'(COLUMNS);
                    n_state = S_SC_RD;
                end else begin
                    n_state = S_FINISH;
                end
            end

            S_SC_RD: begin
                n_state = S_SC_WR;
            end

            // Move the cell one row up
            S_SC_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_scan - AW'(COLUMNS);
                ram_wdata = ram_rdata;
                if (r_scan == AW'(CELL_COUNT - 1)) begin
                    n_scan  = AW'(CELL_COUNT - COLUMNS);
                    n_state = S_SC_FILL;
                end else begin
                    n_scan  = r_scan + AW'(1);
                    n_state = S_SC_RD;
                end
            end

            // Blank the bottom row
            S_SC_FILL: begin
                ram_we    = 1'b1;
                ram_wdata = {r_attr, tcw_pkg::CH_SPACE};
                if (r_scan == AW'(CELL_COUNT - 1)) begin
                    n_scan   = '0;
                    n_cursor = r_cursor - CW'(COLUMNS);
                    n_line   = (r_line >= CW'(COLUMNS)) ? (r_line - CW'(COLUMNS)) : '0;
                    n_state  = S_CHECK;
                end else begin
                    n_scan = r_scan + AW'(1);
                end
            end

            // Load the result register once it is free
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_cursor = tcw_pkg::POS_W'(r_cursor);
                    n_out_line   = tcw_pkg::POS_W'(r_line);
                    n_out_value  = r_value;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_scan      <= '0;
            r_cursor    <= '0;
            r_line      <= '0;
            r_attr      <= tcw_pkg::ATTR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_scan      <= n_scan;
            r_cursor    <= n_cursor;
            r_line      <= n_line;
            r_attr      <= n_attr;
            r_out_valid <= n_out_valid;
        end
        r_char       <= n_char;
        r_value      <= n_value;
        r_quo        <= n_quo;
        r_out_cursor <= n_out_cursor;
        r_out_line   <= n_out_line;
        r_out_value  <= n_out_value;
    end

    // The cursor lies on the screen whenever a new command can enter
    a_cursor_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_cursor < CW'(CELL_COUNT)))
        else $error("cursor off screen while idle");

    // The line start never lies past the cursor
    a_line_not_past_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_line_start <= o_cursor_pos))
        else $error("line start past cursor");

    // One command at a time: ready drops after an accepted transaction
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_in_ready)
        else $error("second command taken while one is in work");

    // No result appears while the clearing pass runs
    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_out_valid)
        else $error("result during clearing pass");

endmodule

@@ bench/text_console_char_writer_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_char_writer_checker: result predictor and comparator
// Watches the attribute port and both channels of the console engine. Each
// accepted command updates a private copy of the screen, cursor and line
// start, and the status it should produce is queued. Each accepted result is
// checked field by field against the oldest queued status.
// ----------------------------------------------------------------------------
module text_console_char_writer_checker #(
    parameter int COLUMNS  = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS     = tcw_pkg::ROWS_DEF,
    parameter int TAB_STOP = tcw_pkg::TAB_STOP_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [tcw_pkg::ATTR_W-1:0] i_cfg_wdata,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic                       i_cmd,
    input  logic [tcw_pkg::CHAR_W-1:0] i_char_code,
    input  logic [tcw_pkg::POS_W-1:0]  i_cell_index,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic [tcw_pkg::POS_W-1:0]  i_cursor_pos,
    input  logic [tcw_pkg::POS_W-1:0]  i_line_start,
    input  logic [tcw_pkg::CELL_W-1:0] i_cell_value,
    output int                         o_fail_count,
    output int                         o_pending,
    output int                         o_scroll_count,
    output int                         o_read_count
);

    localparam int CELL_COUNT = COLUMNS * ROWS;

    typedef struct packed {
        logic [tcw_pkg::POS_W-1:0]  cursor_pos;
        logic [tcw_pkg::POS_W-1:0]  line_start;
        logic [tcw_pkg::CELL_W-1:0] cell_value;
    } t_console_status;

    // Private copy of the console state
    logic [tcw_pkg::CELL_W-1:0] screen_model [CELL_COUNT];
    logic [tcw_pkg::ATTR_W-1:0] text_attr_model;
    int                         cursor_model;
    int                         line_base_model;

    t_console_status            expected_status_q[$];

    initial begin
        o_fail_count   = 0;
        o_pending      = 0;
        o_scroll_count = 0;
        o_read_count   = 0;
    end

    // Return the model to its power-up state and empty the status queue
    task automatic clear_console_model();
        for (int k = 0; k < CELL_COUNT; k++) begin
            screen_model[k] = tcw_pkg::CELL_RESET;
        end
        cursor_model    = 0;
        line_base_model = 0;
        text_attr_model = tcw_pkg::ATTR_RESET;
        expected_status_q.delete();
    endtask

    // Apply one command to the copy of the state and form its status
    task automatic apply_console_cmd(
        input  logic                       cmd,
        input  logic [tcw_pkg::CHAR_W-1:0] ch,
        input  logic [tcw_pkg::POS_W-1:0]  idx,
        output t_console_status            status
    );
        int row_start;
        status.cell_value = '0;
        if (cmd == tcw_pkg::CMD_PUT) begin
            row_start = cursor_model - (cursor_model % COLUMNS);
            case (ch)
                tcw_pkg::CH_NUL: ;
                tcw_pkg::CH_TAB: begin
                    cursor_model = cursor_model + TAB_STOP - (cursor_model % TAB_STOP);
                end
                tcw_pkg::CH_LF: begin
                    screen_model[cursor_model] = '0;
                    cursor_model    = row_start + COLUMNS;
                    line_base_model = cursor_model;
                end
                tcw_pkg::CH_CR: begin
                    cursor_model    = row_start;
                    line_base_model = cursor_model;
                end
                tcw_pkg::CH_BS: begin
                    if (line_base_model < cursor_model) begin
                        cursor_model--;
                    end
                    screen_model[cursor_model] = {text_attr_model, tcw_pkg::CH_NULL};
                end
                default: begin
                    screen_model[cursor_model] = {text_attr_model, ch};
                    cursor_model++;
                end
            endcase
            // Scroll up one row at a time until the cursor is back on screen
            while (cursor_model >= CELL_COUNT) begin
                for (int k = 0; k < CELL_COUNT - COLUMNS; k++) begin
                    screen_model[k] = screen_model[k + COLUMNS];
                end
                for (int k = CELL_COUNT - COLUMNS; k < CELL_COUNT; k++) begin
                    screen_model[k] = {text_attr_model, tcw_pkg::CH_SPACE};
                end
                cursor_model    -= COLUMNS;
                line_base_model = (line_base_model >= COLUMNS) ?
                                  line_base_model - COLUMNS : 0;
                o_scroll_count++;
            end
        end else if (idx < CELL_COUNT) begin
            status.cell_value = screen_model[idx];
        end
        status.cursor_pos = cursor_model[tcw_pkg::POS_W-1:0];
        status.line_start = line_base_model[tcw_pkg::POS_W-1:0];
    endtask

    // Track writes, predict on input transactions, compare on output ones
    always @(posedge i_clk) begin
        t_console_status status;
        t_console_status want;
        if (!i_rst_n) begin
            clear_console_model();
        end else begin
            if (i_cfg_we) begin
                text_attr_model = i_cfg_wdata;
            end
            if (i_in_valid && i_in_ready) begin
                apply_console_cmd(i_cmd, i_char_code, i_cell_index, status);
                expected_status_q.push_back(status);
                if (i_cmd == tcw_pkg::CMD_READ) begin
                    o_read_count++;
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_status_q.size() == 0) begin
                    $error("unexpected result: cursor_pos %0d line_start %0d cell_value %h",
                           i_cursor_pos, i_line_start, i_cell_value);
                    o_fail_count++;
                end else begin
                    want = expected_status_q.pop_front();
                    if (i_cursor_pos !== want.cursor_pos) begin
                        $error("cursor_pos mismatch: expected %0d, actual %0d",
                               want.cursor_pos, i_cursor_pos);
                        o_fail_count++;
                    end
                    if (i_line_start !== want.line_start) begin
                        $error("line_start mismatch: expected %0d, actual %0d",
                               want.line_start, i_line_start);
                        o_fail_count++;
                    end
                    if (i_cell_value !== want.cell_value) begin
                        $error("cell_value mismatch: expected %h, actual %h",
                               want.cell_value, i_cell_value);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = expected_status_q.size();
    end

endmodule

@@ bench/text_console_char_writer_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_char_writer_unit_tb: testbench for the text console engine
// Drives put and read commands in bursts against a stalling receiver, with
// a directed opening, one long unbroken line that scrolls the screen until
// the line start bottoms out, and mixed phases under several attributes.
// A checker beside the block predicts every result and reports mismatches.
// ----------------------------------------------------------------------------
module text_console_char_writer_unit_tb;

    localparam int CELLS             = tcw_pkg::COLUMNS_DEF * tcw_pkg::ROWS_DEF;
    localparam int INDEX_MAX         = (1 << tcw_pkg::POS_W) - 1;
    localparam int PHASE_ITEMS       = 70;
    localparam int LONG_LINE_CAP     = 900;
    localparam int LONG_LINE_SCROLLS = 3;
    localparam int HOLD_CYCLES       = 600;
    localparam int SETTLE_CYCLES     = 16;
    localparam int DRAIN_CYCLES      = 64;
    localparam int TIMEOUT_NS        = 40_000_000;

    typedef struct {
        logic                       cmd;
        logic [tcw_pkg::CHAR_W-1:0] char_code;
        logic [tcw_pkg::POS_W-1:0]  cell_index;
    } t_console_cmd;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [tcw_pkg::ATTR_W-1:0] i_cfg_wdata;
    logic                       i_in_valid;
    logic                       o_in_ready;
    logic                       i_cmd;
    logic [tcw_pkg::CHAR_W-1:0] i_char_code;
    logic [tcw_pkg::POS_W-1:0]  i_cell_index;
    logic                       o_out_valid;
    logic                       i_out_ready;
    logic [tcw_pkg::POS_W-1:0]  o_cursor_pos;
    logic [tcw_pkg::POS_W-1:0]  o_line_start;
    logic [tcw_pkg::CELL_W-1:0] o_cell_value;

    int fail_count;
    int pending;
    int scroll_count;
    int read_count;
    int phase_num;
    int burst_left;
    int cmds_sent;
    int attr_settings;

    text_console_char_writer_unit #(
        .COLUMNS  (tcw_pkg::COLUMNS_DEF),
        .ROWS     (tcw_pkg::ROWS_DEF),
        .TAB_STOP (tcw_pkg::TAB_STOP_DEF)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cmd        (i_cmd),
        .i_char_code  (i_char_code),
        .i_cell_index (i_cell_index),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_cursor_pos (o_cursor_pos),
        .o_line_start (o_line_start),
        .o_cell_value (o_cell_value)
    );

    text_console_char_writer_checker #(
        .COLUMNS  (tcw_pkg::COLUMNS_DEF),
        .ROWS     (tcw_pkg::ROWS_DEF),
        .TAB_STOP (tcw_pkg::TAB_STOP_DEF)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_cmd          (i_cmd),
        .i_char_code    (i_char_code),
        .i_cell_index   (i_cell_index),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_cursor_pos   (o_cursor_pos),
        .i_line_start   (o_line_start),
        .i_cell_value   (o_cell_value),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_scroll_count (scroll_count),
        .o_read_count   (read_count)
    );

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Stop a hung run
    initial begin
        #(TIMEOUT_NS);
        $display("FAILURE");
        $finish;
    end

    function automatic t_console_cmd make_cmd(logic cmd, int ch, int idx);
        t_console_cmd c;
        c.cmd        = cmd;
        c.char_code  = ch[tcw_pkg::CHAR_W-1:0];
        c.cell_index = idx[tcw_pkg::POS_W-1:0];
        return c;
    endfunction

    // Pick a random command; a long line carries no newline or carriage return
    function automatic t_console_cmd pick_random_cmd(bit long_line);
        t_console_cmd c;
        int r;
        c.cmd        = tcw_pkg::CMD_PUT;
        c.char_code  = tcw_pkg::CHAR_W'($urandom_range(0, 255));
        c.cell_index = tcw_pkg::POS_W'($urandom_range(0, INDEX_MAX));
        r = $urandom_range(0, 99);
        if (r < (long_line ? 8 : 25)) begin
            c.cmd = tcw_pkg::CMD_READ;
            r = $urandom_range(0, 99);
            if (r < 10) begin
                c.cell_index = tcw_pkg::POS_W'($urandom_range(CELLS, INDEX_MAX));
            end else if (r < 45) begin
                c.cell_index = tcw_pkg::POS_W'($urandom_range(CELLS - tcw_pkg::COLUMNS_DEF,
                                                              CELLS - 1));
            end else begin
                c.cell_index = tcw_pkg::POS_W'($urandom_range(0, CELLS - 1));
            end
        end else begin
            r = $urandom_range(0, 99);
            if (long_line) begin
                if (r < 80) c.char_code = tcw_pkg::CH_TAB;
                else if (r < 92) c.char_code =
                    tcw_pkg::CHAR_W'($urandom_range(tcw_pkg::CH_SPACE, 255));
                else if (r < 96) c.char_code = tcw_pkg::CH_NUL;
                else c.char_code = tcw_pkg::CH_BS;
            end else begin
                if (r < 12) c.char_code = tcw_pkg::CH_LF;
                else if (r < 20) c.char_code = tcw_pkg::CH_TAB;
                else if (r < 26) c.char_code = tcw_pkg::CH_CR;
                else if (r < 36) c.char_code = tcw_pkg::CH_BS;
                else if (r < 40) c.char_code = tcw_pkg::CH_NUL;
            end
        end
        return c;
    endfunction

    // Offer one command, opening a new burst after a random gap; hold until accepted
    task automatic offer_cmd(input t_console_cmd c);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                i_in_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_cmd        = c.cmd;
        i_char_code  = c.char_code;
        i_cell_index = c.cell_index;
        i_in_valid   = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        cmds_sent++;
    endtask

    // Drain the block, let it settle, then write the attribute register
    task automatic set_text_attr(input logic [tcw_pkg::ATTR_W-1:0] value);
        i_in_valid = 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_wdata = value;
        i_cfg_we    = 1'b1;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        @(negedge i_clk);
        attr_settings++;
    endtask

    // Receiver: random stall pattern, plus one long hold-off in phases two and four
    initial begin
        bit [7:0] hold_done;
        hold_done   = '0;
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if ((phase_num == 2 || phase_num == 4) && !hold_done[phase_num]) begin
                hold_done[phase_num] = 1'b1;
                i_out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else if ($urandom_range(0, 3) == 0) begin
                i_out_ready = 1'b1;
                repeat ($urandom_range(20, 60)) @(negedge i_clk);
            end else begin
                i_out_ready = 1'b1;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
                i_out_ready = 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge i_clk);
            end
        end
    end

    // Stimulus and verdict
    initial begin
        t_console_cmd directed_q[$];
        int start_scrolls;
        int n;
        logic [tcw_pkg::ATTR_W-1:0] attr_v;

        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        i_in_valid    = 1'b0;
        i_cmd         = tcw_pkg::CMD_PUT;
        i_char_code   = '0;
        i_cell_index  = '0;
        phase_num     = 0;
        burst_left    = 0;
        cmds_sent     = 0;
        attr_settings = 0;

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Wait out the clearing pass
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);

        // Directed opening at the reset attribute
        directed_q.push_back(make_cmd(tcw_pkg::CMD_READ, 8'hFF, 0));
        directed_q.push_back(make_cmd(tcw_pkg::CMD_READ, 8'h00, CELLS - 1));
        directed_q.push_back(make_cmd(tcw_pkg::CMD_READ, 8'h41, CELLS));
        directed_q.push_back(make_cmd(tcw_pkg::CMD_READ, 8'h00, INDEX_MAX));
        directed_q.push_back(make_cmd(tcw_pkg::CMD_PUT, tcw_pkg::CH_BS, 0)); // at line start
        directed_q.push_back(make_cmd(tcw_pkg::CMD_PUT, 8'h41, INDEX_MAX));
        directed_q.push_back(make_cmd(tcw_pkg::CMD_PUT, 8'hFF, 0));
        directed_q.push_back(make_cmd(tcw_pkg::CMD_PUT, 8'h01, 0));
        directed_q.push_back(make_cmd(tcw_pkg::CMD_PUT, tcw_pkg::CH_NUL, 0));
        directed_q.push_back(make_cmd(tcw_pkg::CMD_PUT, tcw_pkg::CH_TAB, 0));
        directed_q.push_back(make_cmd(tcw_pkg::CMD_PUT, tcw_pkg::CH_TAB, 0)); // from a stop
        directed_q.push_back(make_cmd(tcw_pkg::CMD_PUT, 8'h80, 0));
        directed_q.push_back(make_cmd(tcw_pkg::CMD_PUT, tcw_pkg::CH_BS, 0));
        directed_q.push_back(make_cmd(tcw_pkg::CMD_PUT, tcw_pkg::CH_CR, 0));
        directed_q.push_back(make_cmd(tcw_pkg::CMD_PUT, tcw_pkg::CH_BS, 0));
        directed_q.push_back(make_cmd(tcw_pkg::CMD_PUT, tcw_pkg::CH_LF, 0));
        directed_q.push_back(make_cmd(tcw_pkg::CMD_PUT, 8'h7F, 0));
        directed_q.push_back(make_cmd(tcw_pkg::CMD_PUT, tcw_pkg::CH_LF, 0));
        directed_q.push_back(make_cmd(tcw_pkg::CMD_READ, 8'h00, 0));
        directed_q.push_back(make_cmd(tcw_pkg::CMD_READ, 8'h0A, 1));
        directed_q.push_back(make_cmd(tcw_pkg::CMD_READ, 8'h00, 2));
        directed_q.push_back(make_cmd(tcw_pkg::CMD_READ, 8'h00, tcw_pkg::COLUMNS_DEF));
        directed_q.push_back(make_cmd(tcw_pkg::CMD_READ, 8'h00, 2 * tcw_pkg::COLUMNS_DEF));
        directed_q.push_back(make_cmd(tcw_pkg::CMD_PUT, tcw_pkg::CH_SPACE, 0));
        directed_q.push_back(make_cmd(tcw_pkg::CMD_READ, 8'h00,
                                      2 * tcw_pkg::COLUMNS_DEF + 1));
        foreach (directed_q[i]) begin
            offer_cmd(directed_q[i]);
        end

        // One long line: scroll until the line start has saturated at zero
        set_text_attr(8'hFF);
        phase_num     = 1;
        start_scrolls = scroll_count;
        n             = 0;
        while (scroll_count - start_scrolls < LONG_LINE_SCROLLS && n < LONG_LINE_CAP) begin
            offer_cmd(pick_random_cmd(1'b1));
            n++;
        end

        // Mixed phases under several attributes
        for (int p = 2; p <= 6; p++) begin
            case (p)
                2:       attr_v = 8'h00;
                6:       attr_v = tcw_pkg::ATTR_RESET;
                default: attr_v = tcw_pkg::ATTR_W'($urandom_range(0, 255));
            endcase
            set_text_attr(attr_v);
            phase_num = p;
            repeat (PHASE_ITEMS) offer_cmd(pick_random_cmd(1'b0));
        end
        i_in_valid = 1'b0;

        // Let the last results arrive, then watch for strays
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Covered %0d commands, %0d of them cell reads, and %0d scrolls",
                 cmds_sent, read_count, scroll_count);
        $display("under %0d attribute writes, with two long receiver hold-offs.",
                 attr_settings);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ text_console_char_writer_unit.f @@
rtl/core/tcw_pkg.sv
rtl/core/tcw_ram.sv
rtl/core/text_console_char_writer_unit.sv
bench/text_console_char_writer_checker.sv
bench/text_console_char_writer_unit_tb.sv
